@@ rtl/hfti_pkg.sv @@
package hfti_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned FracWidth = 24;
    localparam int unsigned LzWidth   = 5;
    localparam int unsigned ExpWidth  = 10;

    localparam logic [WordWidth-1:0] QUIET_NAN  = 32'h7fc0_0000;
    localparam logic [WordWidth-1:0] MAX_FINITE = 32'h7f7f_ffff;

    localparam logic signed [ExpWidth-1:0] EXP_OFFSET = 10'sd130;
    localparam logic signed [ExpWidth-1:0] EXP_MAX    = 10'sd254;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_NAN,
        KIND_NORM
    } hfti_kind_t;

    typedef struct packed {
        hfti_kind_t                  kind;
        logic                        sign;
        logic signed [ExpWidth-1:0]  exp;
        logic [FracWidth-1:0]        frac;
        logic [LzWidth-1:0]          lz;
        logic                        last;
    } hfti_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hfti_q_status_t;

    function automatic logic [WordWidth-1:0] reverse_bytes(input logic [WordWidth-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // leading zero count of a nonzero fraction
    function automatic logic [LzWidth-1:0] lead_zeros(input logic [FracWidth-1:0] f);
        logic [LzWidth-1:0] lz;
        lz = '0;
        for (int i = 0; i < FracWidth; i++)
        begin
            if (f[i])
            begin
                lz = LzWidth'(FracWidth - 1 - i);
            end
        end
        return lz;
    endfunction

endpackage

@@ rtl/hfti_if.sv @@
interface hfti_in_if
    import hfti_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [WordWidth-1:0] hex_word;
    logic                 in_last;

    modport source (output valid, output hex_word, output in_last, input ready);
    modport sink (input valid, input hex_word, input in_last, output ready);
endinterface

interface hfti_out_if
    import hfti_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [WordWidth-1:0] ieee_word;
    logic                 out_last;

    modport source (output valid, output ieee_word, output out_last, input ready);
    modport sink (input valid, input ieee_word, input out_last, output ready);
endinterface

interface hfti_cfg_if;
    logic valid;
    logic ready;
    logic input_swap_off;

    modport source (output valid, output input_swap_off, input ready);
    modport sink (input valid, input input_swap_off, output ready);
endinterface

@@ rtl/hex_float_to_ieee_single.sv @@
// Converts base-16 floating-point words (sign, excess-64 exponent, 24-bit fraction) to
// IEEE 754 single precision, with optional byte reversal of each input word set by the
// one-bit configuration register (reset 1: no reversal). One word per cycle is sustained
// while the output is ready; each accepted word is queued, then registered at the output.
// The front stage swaps, classifies and counts leading zeros, a queue of QUEUE_DEPTH entries
// decouples it from the back stage, which normalizes, saturates and registers the result.
// Overflow saturates to the largest finite value, underflow flushes to +0, and a nonzero
// word with zero fraction yields the quiet NaN 0x7fc00000.
module hex_float_to_ieee_single
    import hfti_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    hfti_cfg_if.sink   cfg,
    hfti_in_if.sink    hex,
    hfti_out_if.source ieee
);

    logic           swap_off_reg;
    logic           push_valid, push_ready;
    hfti_item_t     push_item;
    logic           pop_valid, pop_ready;
    hfti_item_t     pop_item;
    hfti_q_status_t q_status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_off_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            swap_off_reg <= cfg.input_swap_off;
        end
    end

    hfti_front u_front (
        .hex        (hex),
        .swap_off   (swap_off_reg),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    hfti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .status     (q_status)
    );

    hfti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .ieee      (ieee)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (hex.valid && hex.ready) |-> !q_status.full)
        else $error("request accepted while queue full");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_no_inf_out: assert property (@(posedge clk) disable iff (!rst_n)
        ieee.valid |-> (ieee.ieee_word[30:23] != 8'hff || ieee.ieee_word == QUIET_NAN))
        else $error("infinity or stray nan produced");

    a_flush_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (ieee.valid && ieee.ieee_word[30:23] == 8'h00) |-> ieee.ieee_word == '0)
        else $error("denormal or negative zero produced");
`endif

endmodule

@@ rtl/hfti_front.sv @@
module hfti_front
    import hfti_pkg::*;
(
    hfti_in_if.sink    hex,
    input  logic       swap_off,
    output logic       push_valid,
    output hfti_item_t push_item,
    input  logic       push_ready
);

    logic [WordWidth-1:0]       word;
    logic [FracWidth-1:0]       frac;
    logic [LzWidth-1:0]         lz;
    logic signed [ExpWidth-1:0] exp4;

    assign word = swap_off ? hex.hex_word : reverse_bytes(hex.hex_word);
    assign frac = word[FracWidth-1:0];
    assign lz   = lead_zeros(frac);
    assign exp4 = $signed({1'b0, word[30:24], 2'b00});

    always_comb
    begin
        push_item.sign = word[31];
        push_item.frac = frac;
        push_item.lz   = lz;
        push_item.last = hex.in_last;
        push_item.exp  = exp4 - EXP_OFFSET - $signed({{(ExpWidth-LzWidth){1'b0}}, lz});
        if (word == '0)
        begin
            push_item.kind = KIND_ZERO;
        end
        else if (frac == '0)
        begin
            push_item.kind = KIND_NAN;
        end
        else
        begin
            push_item.kind = KIND_NORM;
        end
    end

    assign push_valid = hex.valid;
    assign hex.ready  = push_ready;

endmodule

@@ rtl/hfti_queue.sv @@
module hfti_queue
    import hfti_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  hfti_item_t     push_item,
    output logic           push_ready,
    output logic           pop_valid,
    output hfti_item_t     pop_item,
    input  logic           pop_ready,
    output hfti_q_status_t status
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    hfti_item_t      mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push, pop;

    assign status.full  = (count_reg == CntW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_item     = mem_reg[rd_ptr_reg];
    assign push         = push_valid && !status.full;
    assign pop          = pop_ready && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CntW'(1);
            2'b01:   count_next = count_reg - CntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/hfti_back.sv @@
module hfti_back
    import hfti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    input  hfti_item_t  pop_item,
    output logic        pop_ready,
    hfti_out_if.source  ieee
);

    logic                 out_valid_reg, out_valid_next;
    logic [WordWidth-1:0] out_word_reg, out_word_next;
    logic                 out_last_reg;
    logic [FracWidth-1:0] norm;
    logic                 pop;

    assign pop_ready = !out_valid_reg || ieee.ready;
    assign pop       = pop_valid && pop_ready;
    assign norm      = pop_item.frac << pop_item.lz;

    always_comb
    begin
        unique case (pop_item.kind)
            KIND_ZERO: out_word_next = '0;
            KIND_NAN:  out_word_next = QUIET_NAN;
            KIND_NORM:
            begin
                if (pop_item.exp > EXP_MAX)
                begin
                    out_word_next = {pop_item.sign, MAX_FINITE[30:0]};
                end
                else if (pop_item.exp <= $signed(ExpWidth'(0)))
                begin
                    out_word_next = '0;
                end
                else
                begin
                    out_word_next = {pop_item.sign, pop_item.exp[7:0], norm[22:0]};
                end
            end
            default:   out_word_next = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (ieee.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg <= out_word_next;
            out_last_reg <= pop_item.last;
        end
    end

    assign ieee.valid     = out_valid_reg;
    assign ieee.ieee_word = out_word_reg;
    assign ieee.out_last  = out_last_reg;

endmodule

@@ tb/tb.sv @@
module tb;
    import hfti_pkg::*;

    typedef struct {
        logic [WordWidth-1:0] ieee_word;
        logic                 last;
    } ieee_result_t;

    class conversion_scoreboard;
        ieee_result_t expected_q[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // expected single-precision pattern for one source word
        function automatic logic [WordWidth-1:0] convert(logic [WordWidth-1:0] raw,
                                                         bit swap_off);
            logic [WordWidth-1:0] w;
            logic [FracWidth-1:0] f;
            int                   e;
            w = swap_off ? raw : reverse_bytes(raw);
            if (w == '0)
                return '0;
            f = w[FracWidth-1:0];
            if (f == '0)
                return QUIET_NAN;
            e = 4 * int'(w[30:24]) - int'(EXP_OFFSET);
            while (!f[FracWidth-1])
            begin
                f = f << 1;
                e--;
            end
            if (e > int'(EXP_MAX))
                return {w[31], 31'h0} | MAX_FINITE;
            if (e <= 0)
                return '0;
            return {w[31], e[7:0], f[22:0]};
        endfunction

        function void note_request(logic [WordWidth-1:0] raw, logic last, bit swap_off);
            ieee_result_t r;
            r.ieee_word = convert(raw, swap_off);
            r.last      = last;
            expected_q.push_back(r);
        endfunction

        task check_result(logic [WordWidth-1:0] ieee_word, logic last);
            ieee_result_t r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %h last %b", ieee_word, last));
                return;
            end
            r = expected_q.pop_front();
            if (ieee_word !== r.ieee_word)
                report($sformatf("ieee_word %h, expected %h", ieee_word, r.ieee_word));
            if (last !== r.last)
                report($sformatf("out_last %b, expected %b", last, r.last));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    hfti_cfg_if cfg_bus();
    hfti_in_if  hex_bus();
    hfti_out_if ieee_bus();

    conversion_scoreboard sb = new();

    bit swap_model   = 1'b1;
    bit gen_swap_off = 1'b1;
    bit no_idle      = 1'b0;
    int hold_cycles  = 0;

    hex_float_to_ieee_single DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .hex   (hex_bus),
        .ieee  (ieee_bus)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                swap_model = cfg_bus.input_swap_off;
            if (hex_bus.valid && hex_bus.ready)
                sb.note_request(hex_bus.hex_word, hex_bus.in_last, swap_model);
            if (ieee_bus.valid && ieee_bus.ready)
                sb.check_result(ieee_bus.ieee_word, ieee_bus.out_last);
        end
    end

    // result side, with an optional long hold-off
    initial
    begin
        ieee_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                ieee_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                ieee_bus.ready <= no_idle || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    task send_item(logic [WordWidth-1:0] raw, logic last);
        if (!no_idle && $urandom_range(0, 99) < 35)
        begin
            hex_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        hex_bus.valid    <= 1'b1;
        hex_bus.hex_word <= raw;
        hex_bus.in_last  <= last;
        do @(posedge clk); while (!hex_bus.ready);
    endtask

    task send_value(logic [WordWidth-1:0] value, logic last);
        logic [WordWidth-1:0] raw;
        raw = gen_swap_off ? value : reverse_bytes(value);
        send_item(raw, last);
    endtask

    // checked between edges so the last request is already noted
    task wait_drained();
        hex_bus.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task write_swap(bit v);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.input_swap_off <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        gen_swap_off = v;
    endtask

    function automatic logic [WordWidth-1:0] make_word();
        logic [WordWidth-1:0] w;
        int                   pick;
        pick = $urandom_range(0, 99);
        w    = $urandom;
        if (pick < 30)
            return w;
        if (pick < 70)
        begin
            if (w[23:0] == '0)
                w[0] = 1'b1;
            return w;
        end
        if (pick < 85)
        begin
            w[23:0] = 24'h1 << $urandom_range(0, 23);
            return w;
        end
        if (pick < 90)
        begin
            w[23:0] = '0;
            return w;
        end
        if (pick < 93)
            return '0;
        // exponents around the underflow and overflow edges
        w[30:24] = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(30, 36))
                                               : 7'($urandom_range(93, 99));
        w[23:0]  = 24'($urandom >> $urandom_range(0, 23));
        if (w[23:0] == '0)
            w[23] = 1'b1;
        return w;
    endfunction

    task automatic run_directed();
        logic [WordWidth-1:0] words[] = '{
            32'h0000_0000, 32'h8000_0000, 32'h7f00_0000, 32'hff00_0000,
            32'hffff_ffff, 32'h7fff_ffff, 32'h00ff_ffff, 32'h0000_0001,
            32'h4110_0000, 32'hc110_0000, 32'h7f00_0001, 32'h2140_0000,
            32'h2120_0000, 32'h6080_0000, 32'he0ff_ffff, 32'h6110_0000,
            32'h4000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'h0080_0000
        };
        foreach (words[i])
            send_value(words[i], i[0]);
    endtask

    task run_random(int count);
        repeat (count)
            send_value(make_word(), $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.input_swap_off <= 1'b1;
        hex_bus.valid          <= 1'b0;
        hex_bus.hex_word       <= '0;
        hex_bus.in_last        <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(200);
        no_idle = 1'b1;
        run_random(150);
        no_idle = 1'b0;

        write_swap(1'b0);
        run_directed();
        hold_cycles = 120;
        run_random(250);
        wait_drained();
        run_random(100);

        write_swap(1'b1);
        run_random(300);

        write_swap(1'b0);
        run_random(350);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
